/* hdl/byte_stream_reassembler_defines.svh */
// assertion macros for the byte stream reassembler
// used by modules that assert; expects clk and rst_n in scope
`ifndef BYTE_STREAM_REASSEMBLER_DEFINES_SVH
`define BYTE_STREAM_REASSEMBLER_DEFINES_SVH
`ifndef SYNTHESIS
`define BSR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bsr assertion failed");
`define BSR_ASSERT_NOW(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("bsr invariant failed");
`else
`define BSR_ASSERT(lbl, prop)
`define BSR_ASSERT_NOW(lbl, cond)
`endif
`endif

/* hdl/bsr_pkg.sv */
// shared types and constants for the byte stream reassembler
// no dependencies
package bsr_pkg;
  localparam int CAPACITY = 4096;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 13;

  typedef enum logic [1:0] {
    OP_SEG = 2'd0,
    OP_END = 2'd1,
    OP_POP = 2'd2,
    OP_NOP = 2'd3
  } bsr_op_t;

  typedef struct packed {
    bsr_op_t     op;
    logic [63:0] idx;
    logic [7:0]  data;
    logic        set_end;
    logic [63:0] end_val;
  } bsr_item_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SEGCHK, S_SCANRD, S_SCAN, S_POPRD, S_DONE
  } bsr_state_t;
endpackage

/* hdl/byte_stream_reassembler.sv */
// stored segment: S_SEGCHK, S_SCANRD, S_SCAN; dropped segment, end mark, unused code: S_DONE
// pop: S_POPRD unless nothing is assembled; the back end takes the next one as a result leaves
// a two-entry command queue takes up to two transactions while the back end works
// results are single-cycle strobes, the receiver cannot stall
// synchronous reset, then a clearing pass over all 4096 entries of the valid memory
// depends on bsr_pkg, bsr_front, bsr_back
module byte_stream_reassembler import bsr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_func,
  input  logic [63:0]      in_stream_index,
  input  logic [7:0]       in_data_byte,
  input  logic             in_eof_here,
  output logic             out_strobe,
  output logic             out_accepted,
  output logic [7:0]       out_read_byte,
  output logic             out_read_valid,
  output logic [63:0]      out_next_index,
  output logic [CNT_W-1:0] out_unassembled_count,
  output logic             out_stream_ended
);
  logic      q_valid, q_pop;
  bsr_item_t q_head;

  bsr_front u_front (
    .clk, .rst_n, .start, .busy, .in_func, .in_stream_index, .in_data_byte,
    .in_eof_here, .q_valid, .q_head, .q_pop
  );

  bsr_back u_back (
    .clk, .rst_n, .q_valid, .q_head, .q_pop, .out_strobe, .out_accepted,
    .out_read_byte, .out_read_valid, .out_next_index, .out_unassembled_count,
    .out_stream_ended
  );
endmodule

/* hdl/bsr_front.sv */
// front end: decodes each command transaction and queues it for the back end
// depends on bsr_pkg
module bsr_front import bsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_stream_index,
  input  logic [7:0]  in_data_byte,
  input  logic        in_eof_here,
  output logic        q_valid,
  output bsr_item_t   q_head,
  input  logic        q_pop
);
  bsr_item_t  q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  bsr_item_t  item;
  logic       push;

  always_comb begin
    item.op      = bsr_op_t'(in_func);
    item.idx     = in_stream_index;
    item.data    = in_data_byte;
    item.set_end = 1'b0;
    item.end_val = in_stream_index;
    unique case (item.op)
      OP_SEG: begin
        item.set_end = in_eof_here;
        item.end_val = in_stream_index + 64'd1;
      end
      OP_END: item.set_end = 1'b1;
      default: item.set_end = 1'b0;
    endcase
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= item;
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

/* hdl/bsr_back.sv */
// back end: ring and valid memories, contiguous advance scan, result register
// depends on bsr_pkg and byte_stream_reassembler_defines.svh
`include "byte_stream_reassembler_defines.svh"
module bsr_back import bsr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  bsr_item_t        q_head,
  output logic             q_pop,
  output logic             out_strobe,
  output logic             out_accepted,
  output logic [7:0]       out_read_byte,
  output logic             out_read_valid,
  output logic [63:0]      out_next_index,
  output logic [CNT_W-1:0] out_unassembled_count,
  output logic             out_stream_ended
);
  logic [7:0] ring_mem [CAPACITY];
  logic       vld_mem  [CAPACITY];

  bsr_state_t        state_r, state_nxt;
  logic [63:0]       au_r, au_nxt, rp_r, rp_nxt, end_r, end_nxt;
  logic              endk_r, endk_nxt;
  logic [CNT_W-1:0]  pend_r, pend_nxt;
  logic [SLOT_W-1:0] clr_r, clr_nxt;
  logic [63:0]       idx_r, idx_nxt;
  logic [7:0]        data_r, data_nxt;
  logic              acc_r, acc_nxt, rv_r, rv_nxt;
  logic [7:0]        rb_r, rb_nxt;
  logic              vrd_r, vwe, vwd;
  logic [SLOT_W-1:0] vraddr, vwaddr, rraddr;
  logic              rwe;
  logic [7:0]        rrd_r;
  logic              strobe_nxt, in_win;
  logic [63:0]       au_plus;

  assign in_win  = (q_head.idx >= au_r) && ((q_head.idx - rp_r) < 64'(CAPACITY));
  assign au_plus = au_r + 64'd1;

  always_comb begin
    state_nxt  = state_r;
    au_nxt     = au_r;
    rp_nxt     = rp_r;
    end_nxt    = end_r;
    endk_nxt   = endk_r;
    pend_nxt   = pend_r;
    clr_nxt    = clr_r;
    idx_nxt    = idx_r;
    data_nxt   = data_r;
    acc_nxt    = acc_r;
    rv_nxt     = rv_r;
    rb_nxt     = rb_r;
    q_pop      = 1'b0;
    vwe        = 1'b0;
    vwd        = 1'b0;
    vwaddr     = au_r[SLOT_W-1:0];
    vraddr     = au_r[SLOT_W-1:0];
    rwe        = 1'b0;
    rraddr     = rp_r[SLOT_W-1:0];
    strobe_nxt = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        vwe     = 1'b1;
        vwaddr  = clr_r;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SLOT_W'(CAPACITY - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          acc_nxt = 1'b0;
          rv_nxt  = 1'b0;
          rb_nxt  = 8'd0;
          if (q_head.set_end) begin
            end_nxt  = q_head.end_val;
            endk_nxt = 1'b1;
          end
          state_nxt = S_DONE;
          unique case (q_head.op)
            OP_SEG: begin
              if (in_win) begin
                idx_nxt   = q_head.idx;
                data_nxt  = q_head.data;
                vraddr    = q_head.idx[SLOT_W-1:0];
                state_nxt = S_SEGCHK;
              end
            end
            OP_POP: begin
              if (au_r != rp_r) begin
                rp_nxt    = rp_r + 64'd1;
                rv_nxt    = 1'b1;
                state_nxt = S_POPRD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SEGCHK: begin
        vwe     = 1'b1;
        vwd     = 1'b1;
        vwaddr  = idx_r[SLOT_W-1:0];
        rwe     = 1'b1;
        acc_nxt = 1'b1;
        if (!vrd_r) pend_nxt = pend_r + 1'b1;
        state_nxt = S_SCANRD;
      end
      S_SCANRD: state_nxt = S_SCAN;
      S_SCAN: begin
        if (vrd_r && ((au_r - rp_r) < 64'(CAPACITY))) begin
          vwe    = 1'b1;
          vwaddr = au_r[SLOT_W-1:0];
          if (pend_r != '0) pend_nxt = pend_r - 1'b1;
          au_nxt = au_plus;
          vraddr = au_plus[SLOT_W-1:0];
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_POPRD: begin
        rb_nxt    = rrd_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    vrd_r <= vld_mem[vraddr];
    if (vwe) vld_mem[vwaddr] <= vwd;
    rrd_r <= ring_mem[rraddr];
    if (rwe) ring_mem[idx_r[SLOT_W-1:0]] <= data_r;
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    data_r <= data_nxt;
    acc_r  <= acc_nxt;
    rv_r   <= rv_nxt;
    rb_r   <= rb_nxt;
    out_accepted          <= acc_r;
    out_read_byte         <= rb_r;
    out_read_valid        <= rv_r;
    out_next_index        <= au_r;
    out_unassembled_count <= pend_r;
    out_stream_ended      <= endk_r && (au_r >= end_r) && (pend_r == '0);
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      au_r       <= '0;
      rp_r       <= '0;
      end_r      <= '0;
      endk_r     <= 1'b0;
      pend_r     <= '0;
      clr_r      <= '0;
      out_strobe <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      au_r       <= au_nxt;
      rp_r       <= rp_nxt;
      end_r      <= end_nxt;
      endk_r     <= endk_nxt;
      pend_r     <= pend_nxt;
      clr_r      <= clr_nxt;
      out_strobe <= strobe_nxt;
    end
  end

  `BSR_ASSERT(a_strobe_after_done, out_strobe |-> $past(state_r) == S_DONE)
  `BSR_ASSERT(a_strobe_gap, out_strobe |=> !out_strobe)
  `BSR_ASSERT_NOW(a_window, (au_r - rp_r) <= 64'(CAPACITY))
  `BSR_ASSERT_NOW(a_pend_bound, pend_r <= CNT_W'(CAPACITY))
endmodule
